// File: hw/rtl/hlfr_pkg.sv
// shared constants and types for the header/length frame receiver
package hlfr_pkg;

  // largest frame the receiver will hold, in bytes
  localparam int MAX_FRAME = 256;
  localparam int POS_W     = $clog2(MAX_FRAME);
  localparam int IDX_W     = POS_W + 1;

  // fixed frame bytes
  localparam logic [7:0] HEAD_FIRST  = 8'hA5;
  localparam logic [7:0] HEAD_SECOND = 8'h5A;
  localparam logic [7:0] MARKER_BYTE = 8'h05;

  // fixed byte positions inside a frame
  localparam logic [IDX_W-1:0] IDX_LEN_LOW  = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_LEN_HIGH = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_MARKER   = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_NINE     = IDX_W'(9);
  localparam logic [IDX_W-1:0] IDX_TYPE     = IDX_W'(10);

  // length field value loaded on every header
  localparam logic [15:0] LEN_INIT = 16'd2;

  // per-byte status codes
  typedef enum logic [2:0] {
    ST_HUNT     = 3'd0,
    ST_STORED   = 3'd1,
    ST_DONE     = 3'd2,
    ST_REJECT   = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  // hunting phase
  typedef enum logic [2:0] {
    PH_WAIT_FIRST  = 3'b001,
    PH_WAIT_SECOND = 3'b010,
    PH_IN_FRAME    = 3'b100
  } phase_t;

  // one result item
  typedef struct packed {
    status_t     status;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [15:0] frame_length;
    logic [7:0]  saved_byte_nine;
    logic [7:0]  saved_byte_ten;
  } result_t;

endpackage

// File: hw/rtl/header_length_frame_receiver.sv
// top level of the header/length frame receiver
// Takes one received byte per transfer and hunts for frames that open with
// 0xA5 0x5A followed by a little-endian 16-bit total length; the byte at index
// 4 must be 0x05 and the byte at index 10 must match cfg_wr_data as last
// written (reset 0). Every byte gives exactly one result carrying its status,
// its index in the frame and, on completion, the bytes at indices 9 and 10.
// A byte goes through an input register, then is decoded combinationally into
// the result register, from which it can transfer when the result side does
// not stall; one byte is taken every cycle while the result side keeps up.
// Throughput is set by the single decode stage updating the hunting state.
module header_length_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  data_byte,
  output logic [7:0]  byte_index,
  output logic [15:0] frame_length,
  output logic [7:0]  saved_byte_nine,
  output logic [7:0]  saved_byte_ten
);

  logic              in_reg_valid;
  logic [7:0]        in_reg_byte;
  logic              advance;
  logic              res_ready;
  hlfr_pkg::result_t decoded;
  hlfr_pkg::result_t res;

  assign advance  = in_reg_valid && res_ready;
  assign in_stall = in_reg_valid && !res_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_byte <= rx_byte;
    end
  end

  // byte decode and frame state
  hlfr_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (advance),
    .byte_in     (in_reg_byte),
    .result      (decoded)
  );

  // result register
  hlfr_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (in_reg_valid),
    .load_data  (decoded),
    .load_ready (res_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (res)
  );

  assign status          = res.status;
  assign data_byte       = res.data_byte;
  assign byte_index      = res.byte_index;
  assign frame_length    = res.frame_length;
  assign saved_byte_nine = res.saved_byte_nine;
  assign saved_byte_ten  = res.saved_byte_ten;

endmodule

// File: hw/rtl/hlfr_parse.sv
// frame hunting state and per-byte decode
module hlfr_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                step,
  input  logic [7:0]          byte_in,
  output hlfr_pkg::result_t   result
);

  logic [7:0]                    type_code;
  hlfr_pkg::phase_t              phase, phase_next;
  logic [hlfr_pkg::POS_W-1:0]    position, position_next;
  logic [15:0]                   length_value, length_value_next;
  logic [7:0]                    length_low, length_low_next;
  logic [7:0]                    byte_nine, byte_nine_next;
  logic [7:0]                    byte_ten, byte_ten_next;
  logic [hlfr_pkg::IDX_W-1:0]    idx;
  logic                          have_len;

  assign idx      = {1'b0, position} + hlfr_pkg::IDX_W'(1);
  assign have_len = idx > hlfr_pkg::IDX_LEN_HIGH;

  // decode one byte against the current phase
  always_comb begin
    phase_next        = phase;
    position_next     = position;
    length_value_next = length_value;
    length_low_next   = length_low;
    byte_nine_next    = byte_nine;
    byte_ten_next     = byte_ten;
    result.status          = hlfr_pkg::ST_HUNT;
    result.data_byte       = byte_in;
    result.byte_index      = 8'd0;
    result.frame_length    = 16'd0;
    result.saved_byte_nine = 8'd0;
    result.saved_byte_ten  = 8'd0;

    unique case (phase)
      hlfr_pkg::PH_WAIT_SECOND: begin
        if (byte_in == hlfr_pkg::HEAD_SECOND) begin
          phase_next        = hlfr_pkg::PH_IN_FRAME;
          position_next     = hlfr_pkg::POS_W'(1);
          length_value_next = hlfr_pkg::LEN_INIT;
          result.status     = hlfr_pkg::ST_STORED;
          result.byte_index = 8'd1;
        end else begin
          phase_next    = hlfr_pkg::PH_WAIT_FIRST;
          position_next = '0;
        end
      end
      hlfr_pkg::PH_IN_FRAME: begin
        result.byte_index   = 8'(idx);
        result.frame_length = have_len ? length_value : 16'd0;
        priority if (idx >= hlfr_pkg::IDX_W'(hlfr_pkg::MAX_FRAME)) begin
          // frame longer than the buffer
          phase_next    = hlfr_pkg::PH_WAIT_FIRST;
          position_next = '0;
          result.status = hlfr_pkg::ST_OVERFLOW;
        end else if (idx == hlfr_pkg::IDX_LEN_LOW) begin
          length_low_next = byte_in;
          position_next   = idx[hlfr_pkg::POS_W-1:0];
          result.status   = hlfr_pkg::ST_STORED;
        end else if (idx == hlfr_pkg::IDX_LEN_HIGH) begin
          length_value_next   = {byte_in, length_low};
          position_next       = idx[hlfr_pkg::POS_W-1:0];
          result.status       = hlfr_pkg::ST_STORED;
          result.frame_length = {byte_in, length_low};
        end else if (idx == hlfr_pkg::IDX_MARKER) begin
          if (byte_in == hlfr_pkg::MARKER_BYTE) begin
            position_next = idx[hlfr_pkg::POS_W-1:0];
            result.status = hlfr_pkg::ST_STORED;
          end else begin
            phase_next    = hlfr_pkg::PH_WAIT_FIRST;
            position_next = '0;
            result.status = hlfr_pkg::ST_REJECT;
          end
        end else if (idx == hlfr_pkg::IDX_TYPE) begin
          if (byte_in == type_code) begin
            byte_ten_next = byte_in;
            position_next = idx[hlfr_pkg::POS_W-1:0];
            result.status = hlfr_pkg::ST_STORED;
          end else begin
            phase_next    = hlfr_pkg::PH_WAIT_FIRST;
            position_next = '0;
            result.status = hlfr_pkg::ST_REJECT;
          end
        end else begin
          // ordinary payload byte, with the end-of-frame check
          if (idx == hlfr_pkg::IDX_NINE) begin
            byte_nine_next = byte_in;
          end
          if ({1'b0, length_value} == 17'(idx) + 17'd1) begin
            phase_next             = hlfr_pkg::PH_WAIT_FIRST;
            position_next          = '0;
            result.status          = hlfr_pkg::ST_DONE;
            result.saved_byte_nine = byte_nine_next;
            result.saved_byte_ten  = byte_ten;
          end else begin
            position_next = idx[hlfr_pkg::POS_W-1:0];
            result.status = hlfr_pkg::ST_STORED;
          end
        end
      end
      default: begin
        if (byte_in == hlfr_pkg::HEAD_FIRST) begin
          phase_next    = hlfr_pkg::PH_WAIT_SECOND;
          position_next = '0;
          result.status = hlfr_pkg::ST_STORED;
        end else begin
          phase_next    = hlfr_pkg::PH_WAIT_FIRST;
          position_next = '0;
        end
      end
    endcase
  end

  // type code register
  always_ff @(posedge clk) begin
    if (rst) begin
      type_code <= 8'd0;
    end else if (cfg_wr_en) begin
      type_code <= cfg_wr_data;
    end
  end

  // hunting state, updated once per handled byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= hlfr_pkg::PH_WAIT_FIRST;
      position     <= '0;
      length_value <= hlfr_pkg::LEN_INIT;
      length_low   <= 8'd0;
      byte_nine    <= 8'd0;
      byte_ten     <= 8'd0;
    end else if (step) begin
      phase        <= phase_next;
      position     <= position_next;
      length_value <= length_value_next;
      length_low   <= length_low_next;
      byte_nine    <= byte_nine_next;
      byte_ten     <= byte_ten_next;
    end
  end

endmodule

// File: hw/rtl/hlfr_out_reg.sv
// result register with valid/stall handshake toward the consumer
module hlfr_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load_valid,
  input  hlfr_pkg::result_t  load_data,
  output logic               load_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output hlfr_pkg::result_t  out_data
);

  hlfr_pkg::result_t held;
  logic              held_valid;

  // free when empty or when the held result transfers this cycle
  assign load_ready = !held_valid || !out_stall;
  assign out_valid  = held_valid;
  assign out_data   = held;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load_ready) begin
      held_valid <= load_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      held <= load_data;
    end
  end

endmodule

// File: hw/rtl/hlfr_checker.sv
// port-level checks for the frame receiver, bound to the top level
module hlfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [7:0]  data_byte,
  input logic [7:0]  byte_index,
  input logic [15:0] frame_length,
  input logic [7:0]  saved_byte_nine,
  input logic [7:0]  saved_byte_ten
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(data_byte)
      && $stable(byte_index) && $stable(frame_length))
    else $error("stalled result changed");

  // a completed frame ends on the byte just before its length
  a_done_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == hlfr_pkg::ST_DONE |-> frame_length == 16'(byte_index) + 16'd1)
    else $error("completion index does not match length");

  // hunting results carry no frame position
  a_hunt_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == hlfr_pkg::ST_HUNT |-> byte_index == 8'd0 && frame_length == 16'd0)
    else $error("hunting result with frame data");

  // saved bytes only show on completion
  a_saved_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != hlfr_pkg::ST_DONE |-> saved_byte_nine == 8'd0
      && saved_byte_ten == 8'd0)
    else $error("saved bytes outside completion");

  // nothing comes out the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind header_length_frame_receiver hlfr_checker u_hlfr_checker (.*);
